// ===== hw/rtl/circular_grid_point_index_defines.svh =====
// ----------------------------------------------------------------------------
// circular_grid_point_index_defines
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_GRID_POINT_INDEX_DEFINES_SVH
`define CIRCULAR_GRID_POINT_INDEX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CGPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cgpi assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define CGPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cgpi assertion failed");

`endif

// ===== hw/rtl/cgpi_pkg.sv =====
// ----------------------------------------------------------------------------
// cgpi_pkg
// Grid geometry, per-column tables and microcode for the grid point indexer.
// ----------------------------------------------------------------------------
package cgpi_pkg;

  localparam int BINS_PER_AXIS   = 38;
  localparam int BIN_WIDTH_UNITS = 80;
  localparam int RADIUS_UNITS    = 1480;

  localparam int COORD_W   = 12;
  localparam int ACC_W     = 13;
  localparam int OUT_PN_W  = 11;
  localparam int OUT_BIN_W = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int BIN_W = $clog2(BINS_PER_AXIS + 1);
  localparam int IDX_W = (BINS_PER_AXIS > 2) ? $clog2(BINS_PER_AXIS) : 1;
  localparam int PN_W  = $clog2(BINS_PER_AXIS * BINS_PER_AXIS + 1);
  localparam int D_W   = $clog2(2 * (BINS_PER_AXIS - 1) * (BINS_PER_AXIS - 1) + 1);

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [IDX_W-1:0] col_idx_t;
  typedef logic [PN_W-1:0]  pn_t;
  typedef logic [D_W-1:0]   dist_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef bin_t col_bin_tab_t [BINS_PER_AXIS];
  typedef pn_t  col_pn_tab_t  [BINS_PER_AXIS];

  localparam bin_t BIN_ONE = BIN_W'(1);
  localparam bin_t BIN_MID = BIN_W'(BINS_PER_AXIS / 2);
  localparam bin_t BIN_MAX = BIN_W'(BINS_PER_AXIS);
  localparam acc_t W_ACC   = ACC_W'(BIN_WIDTH_UNITS);

  // points in column i: twice the half-up rounded half chord, in bins
  function automatic int col_count_f(int i);
    longint xc2;
    longint e;
    longint r2;
    int     k;
    bit     stop;
    xc2  = longint'(2 * i + 1 - BINS_PER_AXIS) * longint'(BIN_WIDTH_UNITS);
    r2   = 4 * longint'(RADIUS_UNITS) * longint'(RADIUS_UNITS);
    k    = 0;
    stop = 1'b0;
    for (int t = 1; t <= BINS_PER_AXIS / 2; t++) begin
      e = longint'(2 * t - 1) * longint'(BIN_WIDTH_UNITS);
      if (!stop && (e * e + xc2 * xc2 <= r2)) k = t;
      else stop = 1'b1;
    end
    return 2 * k;
  endfunction

  function automatic col_bin_tab_t build_lo();
    col_bin_tab_t tab;
    for (int i = 0; i < BINS_PER_AXIS; i++)
      tab[i] = BIN_W'((BINS_PER_AXIS - col_count_f(i)) / 2 + 1);
    return tab;
  endfunction

  function automatic col_bin_tab_t build_hi();
    col_bin_tab_t tab;
    for (int i = 0; i < BINS_PER_AXIS; i++)
      tab[i] = BIN_W'((BINS_PER_AXIS - col_count_f(i)) / 2 + col_count_f(i));
    return tab;
  endfunction

  function automatic col_pn_tab_t build_prefix();
    col_pn_tab_t tab;
    int          sum;
    sum = 0;
    for (int i = 0; i < BINS_PER_AXIS; i++) begin
      tab[i] = PN_W'(sum);
      sum    = sum + col_count_f(i);
    end
    return tab;
  endfunction

  function automatic int total_points_f();
    int sum;
    sum = 0;
    for (int i = 0; i < BINS_PER_AXIS; i++) sum = sum + col_count_f(i);
    return sum;
  endfunction

  // lowest and highest valid row per column, points before each column
  localparam col_bin_tab_t COL_LO     = build_lo();
  localparam col_bin_tab_t COL_HI     = build_hi();
  localparam col_pn_tab_t  COL_PREFIX = build_prefix();
  localparam int           TOTAL_POINTS = total_points_f();

  function automatic col_idx_t col_of(bin_t b);
    bin_t t;
    t = b - BIN_ONE;
    return t[IDX_W-1:0];
  endfunction

  function automatic logic bin_valid(bin_t bx, bin_t by);
    col_idx_t c;
    c = col_of(bx);
    return (by >= COL_LO[c]) && (by <= COL_HI[c]);
  endfunction

  function automatic pn_t point_of(bin_t bx, bin_t by);
    col_idx_t c;
    c = col_of(bx);
    return COL_PREFIX[c] + PN_W'(by) - PN_W'(COL_LO[c]);
  endfunction

  // datapath operations and jump conditions
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_BIN,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_IN_FIRE,
    COND_BIN_DONE,
    COND_HIT_OK,
    COND_SCAN_END,
    COND_OUT_FREE
  } cond_t;

  typedef logic [2:0] step_t;

  localparam int    NUM_STEPS  = 5;
  localparam step_t STEP_LOAD  = 3'd0;
  localparam step_t STEP_BIN   = 3'd1;
  localparam step_t STEP_CHECK = 3'd2;
  localparam step_t STEP_SCAN  = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;  // taken when cond holds
    step_t alt;   // taken otherwise
  } ucode_t;

  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{OP_LOAD,      COND_IN_FIRE,  STEP_BIN,  STEP_LOAD},
    '{OP_BIN,       COND_BIN_DONE, STEP_CHECK, STEP_BIN},
    '{OP_SCAN_INIT, COND_HIT_OK,   STEP_EMIT, STEP_SCAN},
    '{OP_SCAN,      COND_SCAN_END, STEP_EMIT, STEP_SCAN},
    '{OP_EMIT,      COND_OUT_FREE, STEP_LOAD, STEP_EMIT}
  };

  typedef struct packed {
    logic in_fire;
    logic bin_done;
    logic hit_ok;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/cgpi_seq.sv =====
// ----------------------------------------------------------------------------
// cgpi_seq
// Step counter and microcode ROM; picks the next step from a datapath flag.
// ----------------------------------------------------------------------------
module cgpi_seq
  import cgpi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output op_t     op
);

  step_t  pc;
  step_t  pc_next;
  ucode_t uw;
  logic   cond_ok;

  assign uw = UCODE[pc];
  assign op = uw.op;

  always_comb begin
    case (uw.cond)
      COND_IN_FIRE:  cond_ok = status.in_fire;
      COND_BIN_DONE: cond_ok = status.bin_done;
      COND_HIT_OK:   cond_ok = status.hit_ok;
      COND_SCAN_END: cond_ok = status.scan_end;
      COND_OUT_FREE: cond_ok = status.out_free;
      default:       cond_ok = 1'b0;
    endcase
    pc_next = cond_ok ? uw.jump : uw.alt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hw/rtl/cgpi_datapath.sv =====
// ----------------------------------------------------------------------------
// cgpi_datapath
// Binning by repeated add/subtract, nearest-bin scan and the output register.
// ----------------------------------------------------------------------------
module cgpi_datapath
  import cgpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  op_t                   op,
  output status_t               status,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x[11:0], pos_y[23:12]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // point_number[10:0], column_bin[16:11],
                                           // row_bin[22:17], zero pad[23]
  output logic                  m_tuser    // snapped
);

  acc_t  acc_x, acc_y;
  bin_t  bx, by;
  bin_t  si, sj;
  bin_t  best_i, best_j;
  dist_t best_d;
  logic  best_found;

  logic  in_fire;
  logic  x_up, x_dn, y_up, y_dn;
  logic  hit_ok, cand_ok, take, out_free;
  dist_t ai, aj;
  dist_t d;
  bin_t  fx, fy;
  logic  found, snap;
  pn_t   pn;

  assign s_tready = (op == OP_LOAD);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // BIN_MID + ceil(coord / width) one bin per cycle, stopping at the grid edge
  assign x_up = (acc_x > 0) && (bx < BIN_MAX);
  assign x_dn = (acc_x <= -W_ACC) && (bx > BIN_ONE);
  assign y_up = (acc_y > 0) && (by < BIN_MAX);
  assign y_dn = (acc_y <= -W_ACC) && (by > BIN_ONE);

  assign hit_ok  = bin_valid(bx, by);
  assign cand_ok = bin_valid(si, sj);

  // absolute bin distances, squared at full distance width
  assign ai = (si >= bx) ? D_W'(si - bx) : D_W'(bx - si);
  assign aj = (sj >= by) ? D_W'(sj - by) : D_W'(by - sj);
  assign d  = ai * ai + aj * aj;
  // strict compare: first minimum in column-major order wins
  assign take = cand_ok && (!best_found || (d < best_d));

  always_comb begin
    status.in_fire  = in_fire;
    status.bin_done = !(x_up || x_dn || y_up || y_dn);
    status.hit_ok   = hit_ok;
    status.scan_end = (si == BIN_MAX) && (sj == BIN_MAX);
    status.out_free = out_free;
  end

  always_comb begin
    snap  = !hit_ok && best_found;
    found = hit_ok || best_found;
    fx    = snap ? best_i : bx;
    fy    = snap ? best_j : by;
    pn    = found ? point_of(fx, fy) : '0;
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_fire) begin
          acc_x <= ACC_W'($signed(s_tdata[COORD_W-1:0]));
          acc_y <= ACC_W'($signed(s_tdata[2*COORD_W-1:COORD_W]));
          bx    <= BIN_MID;
          by    <= BIN_MID;
        end
      end
      OP_BIN: begin
        if (x_up) begin
          acc_x <= acc_x - W_ACC;
          bx    <= bx + BIN_ONE;
        end else if (x_dn) begin
          acc_x <= acc_x + W_ACC;
          bx    <= bx - BIN_ONE;
        end
        if (y_up) begin
          acc_y <= acc_y - W_ACC;
          by    <= by + BIN_ONE;
        end else if (y_dn) begin
          acc_y <= acc_y + W_ACC;
          by    <= by - BIN_ONE;
        end
      end
      OP_SCAN_INIT: begin
        si         <= BIN_ONE;
        sj         <= BIN_ONE;
        best_found <= 1'b0;
      end
      OP_SCAN: begin
        if (take) begin
          best_d     <= d;
          best_i     <= si;
          best_j     <= sj;
          best_found <= 1'b1;
        end
        if (sj == BIN_MAX) begin
          sj <= BIN_ONE;
          si <= si + BIN_ONE;
        end else begin
          sj <= sj + BIN_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == OP_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && out_free) begin
      m_tdata <= {1'b0, OUT_BIN_W'(fy), OUT_BIN_W'(fx), OUT_PN_W'(pn)};
      m_tuser <= snap;
    end
  end

endmodule

// ===== hw/rtl/circular_grid_point_index.sv =====
// Steps: load, binning one bin per cycle, check and emit; a hit bin outside
//   the circle adds a full scan of all 38 x 38 bins, one bin per cycle.
// Flow: one beat in flight at a time; the next beat can be taken in the cycle after
//   the result enters the output register.
// Reset: synchronous, active high; clears the step counter and output valid.
// ----------------------------------------------------------------------------
// circular_grid_point_index
// Maps a hit position to the number of the nearest grid point in the circle.
// ----------------------------------------------------------------------------
module circular_grid_point_index
  import cgpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x[11:0], pos_y[23:12]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // point_number[10:0], column_bin[16:11],
                                           // row_bin[22:17], zero pad[23]
  output logic                  m_tuser    // snapped
);

  op_t     op;
  status_t status;

  cgpi_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  cgpi_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hw/rtl/cgpi_checker.sv =====
// ----------------------------------------------------------------------------
// cgpi_checker
// Port-level checks on the grid point indexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_grid_point_index_defines.svh"

module cgpi_checker
  import cgpi_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // a held result beat keeps its payload
  `CGPI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // one item at a time: no second beat right after a taken one
  `CGPI_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // chosen bins stay on the grid
  `CGPI_ASSERT_IMP(a_bins_on_grid, m_tvalid, (m_tdata[16:11] != 0) && (m_tdata[16:11] <= BINS_PER_AXIS) && (m_tdata[22:17] != 0) && (m_tdata[22:17] <= BINS_PER_AXIS))

  // point number lies below the number of points in the circle
  `CGPI_ASSERT_IMP(a_point_range, m_tvalid, (m_tdata[10:0] == 0) || (m_tdata[10:0] < TOTAL_POINTS))

endmodule

bind circular_grid_point_index cgpi_checker u_cgpi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
